@@ design/dnfc_pkg.sv @@
// Shared types, character codes and parse functions for the decimal number field classifier.
`timescale 1ns / 1ps
package dnfc_pkg;

	localparam int CHAR_W = 8;
	localparam int TDATA_W = 8;

	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_EXP   = 8'h65;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

	typedef enum logic [7:0] {
		PH_START    = 8'b0000_0001,
		PH_SIGN     = 8'b0000_0010,
		PH_INT      = 8'b0000_0100,
		PH_FRAC     = 8'b0000_1000,
		PH_EXP_MARK = 8'b0001_0000,
		PH_EXP_SIGN = 8'b0010_0000,
		PH_EXP_DIG  = 8'b0100_0000,
		PH_REJECT   = 8'b1000_0000
	} phase_t;

	typedef enum logic [1:0] {
		CLASS_NONE = 2'd0,
		CLASS_INT  = 2'd1,
		CLASS_REAL = 2'd2
	} class_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_byte;
		logic              field_end;
		logic              empty_field;
	} item_t;

	typedef struct packed {
		logic   has_result;
		class_t field_class;
	} result_t;

	function automatic phase_t next_phase(input phase_t ph, input logic [CHAR_W-1:0] c);
		logic d;
		logic s;
		phase_t nxt;
		d = (c >= CH_ZERO) && (c <= CH_NINE);
		s = (c == CH_PLUS) || (c == CH_MINUS);
		nxt = PH_REJECT;
		case (ph)
			PH_START: begin
				if (s) nxt = PH_SIGN;
				else if (d) nxt = PH_INT;
			end
			PH_SIGN: begin
				if (d) nxt = PH_INT;
			end
			PH_INT: begin
				if (d) nxt = PH_INT;
				else if (c == CH_POINT) nxt = PH_FRAC;
				else if (c == CH_EXP) nxt = PH_EXP_MARK;
			end
			PH_FRAC: begin
				if (d) nxt = PH_FRAC;
				else if (c == CH_EXP) nxt = PH_EXP_MARK;
			end
			PH_EXP_MARK: begin
				if (s) nxt = PH_EXP_SIGN;
				else if (d) nxt = PH_EXP_DIG;
			end
			PH_EXP_SIGN, PH_EXP_DIG: begin
				if (d) nxt = PH_EXP_DIG;
			end
			default: nxt = PH_REJECT;
		endcase
		return nxt;
	endfunction

	function automatic class_t phase_class(input phase_t ph);
		class_t cl;
		case (ph)
			PH_INT:              cl = CLASS_INT;
			PH_FRAC, PH_EXP_DIG: cl = CLASS_REAL;
			default:             cl = CLASS_NONE;
		endcase
		return cl;
	endfunction

endpackage

@@ design/dnfc_phase.sv @@
// Parse phase register and its per-byte update.
`timescale 1ns / 1ps
module dnfc_phase
	import dnfc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	output result_t res
);

	phase_t phase_q;
	phase_t phase_nxt;

	assign phase_nxt = next_phase(phase_q, item.char_byte);

	always_comb begin
		res.has_result  = item.field_end | item.empty_field;
		res.field_class = item.empty_field ? CLASS_NONE : phase_class(phase_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
		end else if (step) begin
			// end of field or empty mark restarts the parse
			if (item.field_end | item.empty_field) phase_q <= PH_START;
			else phase_q <= phase_nxt;
		end
	end

endmodule

@@ design/dnfc_out_reg.sv @@
// Output word register for the result channel.
`timescale 1ns / 1ps
module dnfc_out_reg
	import dnfc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  class_t             field_class,
	output logic               free,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata    // [1:0] field_class, rest zero
);

	logic   valid_q;
	class_t class_q;

	assign free          = !valid_q | m_axis_tready;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {{(TDATA_W-2){1'b0}}, class_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) class_q <= field_class;
	end

endmodule

@@ design/decimal_number_field_classifier.sv @@
// Top level of the decimal number field classifier.
`timescale 1ns / 1ps
// Classifies one text field as non-numeric, integral or real.
// Input channel: one byte of the field per word; tlast marks the final byte of
// the field, tuser marks a zero-length field (its byte is ignored).
// Output channel: one word per field, class in tdata[1:0] (0 non-numeric,
// 1 integral, 2 real), sent after the last byte or an empty mark.
// Grammar: [+|-] digit+ ['.' digit*] ['e' [+|-] digit+].
// Throughput: one byte per cycle, sustained, while the output is taken.
// Path: a result word passes through two registers: its last byte is first
// captured in the input register, then the phase update loads the output
// register, where the word is held until it is taken.
// Reset clears the parse phase to start of field and empties both registers.
// When the receiver stalls, the result waits in the output register; bytes that
// give no result still flow, and the input stalls only once a second result
// is waiting behind the held one.
module decimal_number_field_classifier
	import dnfc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [CHAR_W-1:0]  s_axis_tdata,    // [7:0] char_byte
	input  logic               s_axis_tlast,    // field_end
	input  logic               s_axis_tuser,    // [0] empty_field
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata     // [1:0] field_class, rest zero
);

	logic    valid_s1;
	item_t   item_s1;
	result_t res;
	logic    out_free;
	logic    adv;

	dnfc_phase u_phase (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.res    (res)
	);

	assign adv           = valid_s1 & (!res.has_result | out_free);
	assign s_axis_tready = !valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready & s_axis_tvalid) begin
			item_s1 <= '{char_byte: s_axis_tdata, field_end: s_axis_tlast,
				empty_field: s_axis_tuser};
		end
	end

	dnfc_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (adv & res.has_result),
		.field_class   (res.field_class),
		.free          (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

@@ design/dnfc_checker.sv @@
// Port-level checks for the decimal number field classifier, bound to the top level.
`timescale 1ns / 1ps
module dnfc_checker
	import dnfc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               s_axis_tvalid,
	input logic               s_axis_tready,
	input logic               s_axis_tlast,
	input logic               s_axis_tuser,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [TDATA_W-1:0] m_axis_tdata
);

	// a held result word keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// class code is one of three, upper bits zero
	a_out_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[TDATA_W-1:2] == '0 && m_axis_tdata[1:0] != 2'd3)
		else $error("bad class word");

	// input only stalls behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output back-pressure");

	// a fresh result follows a field-ending word taken before it
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |->
			$past(s_axis_tvalid && s_axis_tready && (s_axis_tlast || s_axis_tuser), 2))
		else $error("result without a field-ending word");

endmodule

bind decimal_number_field_classifier dnfc_checker u_dnfc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
